/* sv/sexpr_byte_tokenizer_macros.svh */
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer assertion macros
// clocked assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SEXPR_BYTE_TOKENIZER_MACROS_SVH
`define SEXPR_BYTE_TOKENIZER_MACROS_SVH
`ifndef SYNTH
// checked only outside reset
`define SBT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbt assertion failed");
// checked at every edge, reset included
`define SBT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sbt assertion failed");
`else
`define SBT_ASSERT(lbl, clk, rst_n, prop)
`define SBT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// sbt_pkg
// types, codes and character classes of the s-expression byte tokenizer
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int FIELD_BITS      = 24;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        KIND_SYM   = 3'd0,
        KIND_NUM   = 3'd1,
        KIND_CMT   = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4,
        KIND_ERR   = 3'd5,
        KIND_END   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SYM  = 2'd1,
        MODE_CMT  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LEAD_OTHER = 2'd0,
        LEAD_SIGN  = 2'd1,
        LEAD_DOT   = 2'd2,
        LEAD_DIGIT = 2'd3
    } t_lead;

    typedef struct packed {
        t_kind                   kind;
        logic [FIELD_BITS-1:0]   offset;
        logic [FIELD_BITS-1:0]   length;
        logic                    last;
    } t_result;

    // results of one item, res0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_sym_char(input logic [7:0] c);
        logic hit;
        case (c) inside
            [8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]: hit = 1'b1;
            // - ! $ % & * + . / : < = > ? @ ^ _ ~
            8'h2d, 8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2b, 8'h2e, 8'h2f,
            8'h3a, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h5e, 8'h5f, 8'h7e:
                hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* sv/sbt_core.sv */
// ----------------------------------------------------------------------------
// sbt_core
// scanner state and per-byte step; yields up to two results per item
// ----------------------------------------------------------------------------
module sbt_core #(
    parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    output sbt_pkg::t_push o_push
);

    localparam int FB = sbt_pkg::FIELD_BITS;

    sbt_pkg::t_mode          r_mode,  n_mode;
    sbt_pkg::t_kind          r_pkind, n_pkind;
    sbt_pkg::t_lead          r_lead,  n_lead;
    logic [1:0]              r_chars, n_chars;
    logic                    r_sdot,  n_sdot;
    logic [OFFSET_BITS-1:0]  r_off,   n_off;
    logic [OFFSET_BITS-1:0]  r_begin, n_begin;

    always_comb begin
        sbt_pkg::t_result f_res;
        sbt_pkg::t_result e_res;
        logic             f_v;
        logic             e_v;
        logic             idle;

        n_mode  = r_mode;
        n_pkind = r_pkind;
        n_lead  = r_lead;
        n_chars = r_chars;
        n_sdot  = r_sdot;
        n_off   = r_off;
        n_begin = r_begin;
        f_v     = 1'b0;
        e_v     = 1'b0;
        idle    = 1'b0;

        // pending token as it stands before this byte
        f_res.kind   = r_pkind;
        f_res.offset = FB'(r_begin);
        f_res.length = FB'(r_off - r_begin);
        f_res.last   = 1'b0;

        e_res.kind   = sbt_pkg::KIND_ERR;
        e_res.offset = FB'(r_off);
        e_res.length = FB'(1);
        e_res.last   = 1'b1;

        if (i_fire) begin
            if (i_end) begin
                f_v          = (r_mode != sbt_pkg::MODE_IDLE);
                e_v          = 1'b1;
                e_res.kind   = sbt_pkg::KIND_END;
                e_res.length = '0;
                n_mode  = sbt_pkg::MODE_IDLE;
                n_pkind = sbt_pkg::KIND_SYM;
                n_lead  = sbt_pkg::LEAD_OTHER;
                n_chars = 2'd0;
                n_sdot  = 1'b0;
                n_off   = '0;
                n_begin = '0;
            end else begin
                case (r_mode)
                    sbt_pkg::MODE_SYM: begin
                        if (sbt_pkg::is_sym_char(i_byte)) begin
                            if (r_chars == 2'd1) begin
                                if ((r_lead == sbt_pkg::LEAD_SIGN ||
                                     r_lead == sbt_pkg::LEAD_DOT) &&
                                    sbt_pkg::is_digit(i_byte)) begin
                                    n_pkind = sbt_pkg::KIND_NUM;
                                end else if (r_lead == sbt_pkg::LEAD_SIGN &&
                                             i_byte == sbt_pkg::CH_DOT) begin
                                    n_sdot = 1'b1;
                                end
                            end else if (r_chars == 2'd2) begin
                                // sign, dot, digit
                                if (r_lead == sbt_pkg::LEAD_SIGN && r_sdot &&
                                    sbt_pkg::is_digit(i_byte)) begin
                                    n_pkind = sbt_pkg::KIND_NUM;
                                end
                            end
                            if (r_chars != 2'd3) begin
                                n_chars = r_chars + 2'd1;
                            end
                        end else begin
                            f_v    = 1'b1;
                            idle   = 1'b1;
                            n_mode = sbt_pkg::MODE_IDLE;
                        end
                    end
                    sbt_pkg::MODE_CMT: begin
                        if (i_byte == sbt_pkg::CH_LF || i_byte == sbt_pkg::CH_CR) begin
                            f_v    = 1'b1;
                            idle   = 1'b1;
                            n_mode = sbt_pkg::MODE_IDLE;
                        end
                    end
                    default: begin
                        idle   = 1'b1;
                        n_mode = sbt_pkg::MODE_IDLE;
                    end
                endcase

                if (idle) begin
                    if (sbt_pkg::is_blank(i_byte)) begin
                        e_v = 1'b0;
                    end else if (i_byte == sbt_pkg::CH_SEMI) begin
                        n_mode  = sbt_pkg::MODE_CMT;
                        n_pkind = sbt_pkg::KIND_CMT;
                        n_lead  = sbt_pkg::LEAD_OTHER;
                    end else if (i_byte == sbt_pkg::CH_OPEN) begin
                        e_v        = 1'b1;
                        e_res.kind = sbt_pkg::KIND_OPEN;
                    end else if (i_byte == sbt_pkg::CH_CLOSE) begin
                        e_v        = 1'b1;
                        e_res.kind = sbt_pkg::KIND_CLOSE;
                    end else if (sbt_pkg::is_digit(i_byte)) begin
                        n_mode  = sbt_pkg::MODE_SYM;
                        n_pkind = sbt_pkg::KIND_NUM;
                        n_lead  = sbt_pkg::LEAD_DIGIT;
                    end else if (i_byte == sbt_pkg::CH_PLUS ||
                                 i_byte == sbt_pkg::CH_MINUS) begin
                        n_mode  = sbt_pkg::MODE_SYM;
                        n_pkind = sbt_pkg::KIND_SYM;
                        n_lead  = sbt_pkg::LEAD_SIGN;
                    end else if (i_byte == sbt_pkg::CH_DOT) begin
                        n_mode  = sbt_pkg::MODE_SYM;
                        n_pkind = sbt_pkg::KIND_SYM;
                        n_lead  = sbt_pkg::LEAD_DOT;
                    end else if (sbt_pkg::is_sym_char(i_byte)) begin
                        n_mode  = sbt_pkg::MODE_SYM;
                        n_pkind = sbt_pkg::KIND_SYM;
                        n_lead  = sbt_pkg::LEAD_OTHER;
                    end else begin
                        e_v = 1'b1;
                    end
                    // a token opened here starts at this byte
                    if (n_mode != sbt_pkg::MODE_IDLE) begin
                        n_chars = 2'd1;
                        n_sdot  = 1'b0;
                        n_begin = r_off;
                    end
                end

                // offset saturates at all ones
                if (r_off != {OFFSET_BITS{1'b1}}) begin
                    n_off = r_off + 1'b1;
                end
            end
        end

        // closing token goes out ahead of the byte's own result
        f_res.last   = !e_v;
        o_push.count = {1'b0, f_v} + {1'b0, e_v};
        o_push.res0  = f_v ? f_res : e_res;
        o_push.res1  = e_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sbt_pkg::MODE_IDLE;
            r_pkind <= sbt_pkg::KIND_SYM;
            r_lead  <= sbt_pkg::LEAD_OTHER;
            r_chars <= 2'd0;
            r_sdot  <= 1'b0;
            r_off   <= '0;
            r_begin <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pkind <= n_pkind;
            r_lead  <= n_lead;
            r_chars <= n_chars;
            r_sdot  <= n_sdot;
            r_off   <= n_off;
            r_begin <= n_begin;
        end
    end

endmodule

/* sv/sbt_outq.sv */
// ----------------------------------------------------------------------------
// sbt_outq
// small result queue: takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
module sbt_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbt_pkg::t_push     i_push,
    input  logic               i_pop,
    output sbt_pkg::t_result   o_head,
    output sbt_pkg::t_q_status o_status
);

    localparam int PB = sbt_pkg::QPTR_BITS;
    localparam int CB = sbt_pkg::QCNT_BITS;

    sbt_pkg::t_result        r_mem [sbt_pkg::QUEUE_DEPTH];
    logic [PB-1:0]           r_wr, n_wr;
    logic [PB-1:0]           r_rd, n_rd;
    logic [CB-1:0]           r_count, n_count;
    logic [PB-1:0]           wr_next;

    assign wr_next = r_wr + PB'(1);

    always_comb begin
        n_wr    = r_wr + PB'(i_push.count);
        n_rd    = r_rd + PB'(i_pop);
        n_count = r_count + CB'(i_push.count) - CB'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.count = r_count;

endmodule

/* sv/sexpr_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer
// s-expression lexer: text bytes in, tokens (kind, offset, length) out
// ----------------------------------------------------------------------------
// input stream (s_axis): one text byte per item in tdata; tuser high marks
// the end of the text, and then tdata is ignored.
// output stream (m_axis): one token per item, kind in tuser, offset and length
// in tdata, tlast high on the final token caused by an input item. the end
// item flushes an open token, then gives an end token, and the next byte
// starts a fresh text at offset 0.
// a token caused by an item passes the input register, then the four-entry
// result queue, before it is valid on m_axis.
// throughput: one input item per cycle while the queue has room; the result
// queue drains one token per cycle while m_axis is ready, so an item that
// closes a token and makes one of its own leaves two tokens to drain. an item
// steps only when the queue has two free slots, which sets the rate under
// back pressure.
// reset (i_rst_n low, synchronous) empties the input register and the queue
// and returns the scanner to offset 0 between tokens.
// when m_axis stalls, tokens stay queued and s_axis tready drops once the
// queue cannot take another item's worth of results.
// ----------------------------------------------------------------------------
`include "sexpr_byte_tokenizer_macros.svh"

module sexpr_byte_tokenizer #(
    parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] end_marker
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [23:0] token_offset, [47:24] token_length
    output logic [2:0]  o_m_axis_tuser,   // [2:0] token_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    localparam int CB = sbt_pkg::QCNT_BITS;
    localparam logic [CB-1:0] Q_FULL     = CB'(sbt_pkg::QUEUE_DEPTH);
    localparam logic [CB-1:0] Q_STEP_MAX = CB'(sbt_pkg::QUEUE_DEPTH - 2);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_end;
    logic               fire;
    logic               pop;
    sbt_pkg::t_push     push;
    sbt_pkg::t_result   head;
    sbt_pkg::t_q_status q_status;

    // room for two results guarantees the step never overfills the queue
    assign fire = r_in_valid && (q_status.count <= Q_STEP_MAX);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tuser;
        end
    end

    sbt_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    sbt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    assign o_m_axis_tvalid = (q_status.count != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = {head.length, head.offset};
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.last;

    `SBT_ASSERT(a_q_bound, i_clk, i_rst_n, q_status.count <= Q_FULL)
    `SBT_ASSERT(a_fire_room, i_clk, i_rst_n, fire |-> q_status.count <= Q_STEP_MAX)
    `SBT_ASSERT(a_end_last, i_clk, i_rst_n, (o_m_axis_tvalid && head.kind == sbt_pkg::KIND_END) |-> o_m_axis_tlast)
    `SBT_ASSERT(a_hold_item, i_clk, i_rst_n, (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
    `SBT_ASSERT_ALWAYS(a_no_push_idle, i_clk, !fire |-> push.count == 2'd0)

endmodule

/* bench/sbt_token_checker.sv */
// ----------------------------------------------------------------------------
// sbt_token_checker
// watches both streams of the tokenizer, predicts the tokens of every
// accepted byte and compares each output item with the oldest prediction
// ----------------------------------------------------------------------------
module sbt_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic [2:0]  i_out_user,
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_tokens
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] OFF_TOP = '1;
    localparam int PRINT_CAP = 100;

    // scanner copy
    sbt_pkg::t_mode scan_state = sbt_pkg::MODE_IDLE;
    sbt_pkg::t_kind open_kind  = sbt_pkg::KIND_SYM;
    sbt_pkg::t_lead open_lead  = sbt_pkg::LEAD_OTHER;
    logic [1:0]     open_len   = '0;
    logic           sign_dot   = 1'b0;
    logic [23:0]    next_off   = '0;
    logic [23:0]    open_off   = '0;

    sbt_pkg::t_result expected_tokens[$];
    int errors = 0;
    int tokens = 0;

    task automatic report(input string what);
        if (errors < PRINT_CAP)
            $display("%0t ns  token %0d: %s", $time, tokens, what);
        errors++;
    endtask

    function automatic logic blank_byte(input logic [7:0] b);
        return b == sbt_pkg::CH_SPACE || (b >= sbt_pkg::CH_TAB && b <= sbt_pkg::CH_CR);
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic symbol_byte(input logic [7:0] b);
        case (b)
            "-", "!", "$", "%", "&", "*", "+", ".", "/", ":", "<", "=", ">", "?", "@",
            "^", "_", "~": return 1'b1;
            default: return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                            digit_byte(b);
        endcase
    endfunction

    function automatic sbt_pkg::t_result make_token(input sbt_pkg::t_kind k,
                                                    input logic [23:0] off,
                                                    input logic [23:0] len);
        sbt_pkg::t_result r;
        r.kind   = k;
        r.offset = off;
        r.length = len;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic clear_scan();
        scan_state = sbt_pkg::MODE_IDLE;
        open_kind  = sbt_pkg::KIND_SYM;
        open_lead  = sbt_pkg::LEAD_OTHER;
        open_len   = '0;
        sign_dot   = 1'b0;
        next_off   = '0;
        open_off   = '0;
    endtask

    task automatic begin_token(input sbt_pkg::t_mode m, input sbt_pkg::t_kind k,
                               input sbt_pkg::t_lead l);
        scan_state = m;
        open_kind  = k;
        open_lead  = l;
        open_len   = 2'd1;
        sign_dot   = 1'b0;
        open_off   = next_off;
    endtask

    // one input item: up to two tokens, the closing one first
    task automatic tokenize_byte(input logic [7:0] b, input logic e);
        sbt_pkg::t_result made[2];
        int n;
        logic closes;
        logic fresh;
        n = 0;
        closes = 1'b0;
        fresh = 1'b1;
        if (e) begin
            closes = scan_state != sbt_pkg::MODE_IDLE;
        end else if (scan_state == sbt_pkg::MODE_SYM) begin
            fresh = !symbol_byte(b);
            closes = fresh;
            if (!fresh) begin
                // number detection looks at the first three bytes only
                if (open_len == 2'd1) begin
                    if ((open_lead == sbt_pkg::LEAD_SIGN || open_lead == sbt_pkg::LEAD_DOT) &&
                        digit_byte(b))
                        open_kind = sbt_pkg::KIND_NUM;
                    else if (open_lead == sbt_pkg::LEAD_SIGN && b == sbt_pkg::CH_DOT)
                        sign_dot = 1'b1;
                end else if (open_len == 2'd2) begin
                    if (open_lead == sbt_pkg::LEAD_SIGN && sign_dot && digit_byte(b))
                        open_kind = sbt_pkg::KIND_NUM;
                end
                if (open_len != 2'd3)
                    open_len = open_len + 2'd1;
            end
        end else if (scan_state == sbt_pkg::MODE_CMT) begin
            fresh = b == sbt_pkg::CH_LF || b == sbt_pkg::CH_CR;
            closes = fresh;
        end

        if (closes) begin
            made[n] = make_token(open_kind, open_off, next_off - open_off);
            n++;
            scan_state = sbt_pkg::MODE_IDLE;
        end

        if (e) begin
            made[n] = make_token(sbt_pkg::KIND_END, next_off, '0);
            n++;
            clear_scan();
        end else begin
            if (fresh && !blank_byte(b)) begin
                if (b == sbt_pkg::CH_SEMI) begin
                    begin_token(sbt_pkg::MODE_CMT, sbt_pkg::KIND_CMT, sbt_pkg::LEAD_OTHER);
                end else if (b == sbt_pkg::CH_OPEN) begin
                    made[n] = make_token(sbt_pkg::KIND_OPEN, next_off, 24'd1);
                    n++;
                end else if (b == sbt_pkg::CH_CLOSE) begin
                    made[n] = make_token(sbt_pkg::KIND_CLOSE, next_off, 24'd1);
                    n++;
                end else if (digit_byte(b)) begin
                    begin_token(sbt_pkg::MODE_SYM, sbt_pkg::KIND_NUM, sbt_pkg::LEAD_DIGIT);
                end else if (b == sbt_pkg::CH_PLUS || b == sbt_pkg::CH_MINUS) begin
                    begin_token(sbt_pkg::MODE_SYM, sbt_pkg::KIND_SYM, sbt_pkg::LEAD_SIGN);
                end else if (b == sbt_pkg::CH_DOT) begin
                    begin_token(sbt_pkg::MODE_SYM, sbt_pkg::KIND_SYM, sbt_pkg::LEAD_DOT);
                end else if (symbol_byte(b)) begin
                    begin_token(sbt_pkg::MODE_SYM, sbt_pkg::KIND_SYM, sbt_pkg::LEAD_OTHER);
                end else begin
                    made[n] = make_token(sbt_pkg::KIND_ERR, next_off, 24'd1);
                    n++;
                end
            end
            if (next_off != OFF_TOP)
                next_off = next_off + 24'd1;
        end

        for (int i = 0; i < n; i++) begin
            made[i].last = i == n - 1;
            expected_tokens.push_back(made[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        sbt_pkg::t_result want;
        if (!i_rst_n) begin
            clear_scan();
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    report($sformatf("unexpected token, kind %0d offset %0d length %0d",
                                     i_out_user, i_out_data[23:0], i_out_data[47:24]));
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_out_user !== want.kind)
                        report($sformatf("kind %0d, expected %s", i_out_user,
                                         want.kind.name()));
                    if (i_out_data[23:0] !== want.offset)
                        report($sformatf("offset %0d, expected %0d", i_out_data[23:0],
                                         want.offset));
                    if (i_out_data[47:24] !== want.length)
                        report($sformatf("length %0d, expected %0d", i_out_data[47:24],
                                         want.length));
                    if (i_out_last !== want.last)
                        report($sformatf("tlast %b, expected %b", i_out_last, want.last));
                    tokens++;
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_in_byte, i_in_end);
        end
        o_errors  <= errors;
        o_pending <= expected_tokens.size();
        o_tokens  <= tokens;
    end

endmodule

/* bench/tb_sexpr_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// tb_sexpr_byte_tokenizer
// drives text bytes and end items into the tokenizer under varying sender
// gaps and receiver stalls; the token checker predicts and compares
// ----------------------------------------------------------------------------
module tb_sexpr_byte_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int SEG_ITEMS   = 95;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = '0;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [47:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    int mismatch_count;
    int pending_tokens;
    int tokens_checked;

    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int cycles         = 0;

    string sym_lead = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!$%&*/:<=>?@^_~";
    string sym_tail = "0123456789+-.0123456789abcxyzQRZ!?*_~/<=>";

    always #5 clk = ~clk;

    sexpr_byte_tokenizer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    sbt_token_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_byte   (s_data),
        .i_in_end    (s_user),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_out_user  (m_user),
        .i_out_last  (m_last),
        .o_errors    (mismatch_count),
        .o_pending   (pending_tokens),
        .o_tokens    (tokens_checked)
    );

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin : rx_side
        int hold_cnt;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_served) begin
                m_ready <= 1'b0;
                hold_cnt = HOLD_CYCLES;
                while (hold_cnt > 0) begin
                    @(posedge clk);
                    hold_cnt--;
                end
                hold_served++;
            end else begin
                m_ready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still expected", cycles,
                     pending_tokens);
            $display("sexpr_byte_tokenizer verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= 8'($urandom_range(255));
            s_user  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= e;
        do @(posedge clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // sender pauses until every predicted token has come out
    task automatic wait_tokens_drained();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending_tokens != 0);
    endtask

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // one lexeme of mostly well-formed text, now and then noise or an end item
    task automatic send_lexeme();
        logic [7:0] text[$];
        logic [7:0] c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 2) begin
            send_byte(8'($urandom_range(255)), 1'b1);
        end else if (pick < 10) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else begin
            if (pick < 30) begin
                text.push_back(pick_from(sym_lead));
            end else if (pick < 48) begin
                case ($urandom_range(3))
                    0: ;
                    1: text.push_back(pick_from("+-"));
                    2: begin
                        text.push_back(pick_from("+-"));
                        text.push_back(sbt_pkg::CH_DOT);
                    end
                    default: text.push_back(sbt_pkg::CH_DOT);
                endcase
                text.push_back(pick_from("0123456789"));
            end else if (pick < 56) begin
                // near misses of a number
                text.push_back(pick_from("+-."));
                if ($urandom_range(1))
                    text.push_back(pick_from(".+-a_Z"));
            end else if (pick < 66) begin
                text.push_back(sbt_pkg::CH_SEMI);
                repeat ($urandom_range(8)) begin
                    do c = 8'($urandom_range(255));
                    while (c == sbt_pkg::CH_LF || c == sbt_pkg::CH_CR);
                    text.push_back(c);
                end
                text.push_back($urandom_range(1) ? sbt_pkg::CH_LF : sbt_pkg::CH_CR);
            end else if (pick < 82) begin
                text.push_back(pick_from("()"));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    c = 8'($urandom_range(8, 13));
                    text.push_back(c == 8'd8 ? sbt_pkg::CH_SPACE : c);
                end
            end
            if (pick < 56) begin
                repeat ($urandom_range(5))
                    text.push_back(pick_from(sym_tail));
            end
            foreach (text[i])
                send_byte(text[i], 1'b0);
        end
    endtask

    initial begin : stimulus
        int seg_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every token kind, number forms, two-token items, end flushes
        send_text("(+5 -.7)\t.5a;x\n");
        send_byte(8'h00, 1'b0);
        send_text("+.x");
        send_byte(8'hff, 1'b0);
        send_text("- 1");
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_tokens_drained();

        // long receiver hold-off while the sender keeps offering
        hold_asks <= hold_asks + 1;
        repeat (30)
            send_text("()");
        wait_tokens_drained();

        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            seg_start = items_sent;
            while (items_sent < seg_start + SEG_ITEMS)
                send_lexeme();
            wait_tokens_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(8'($urandom_range(255)), 1'b1);
        wait_tokens_drained();
        repeat (8) @(posedge clk);

        $display("%0d input items (directed text, one long output hold-off, eight random",
                 items_sent);
        $display("segments with sender gaps and receiver stalls), %0d tokens compared",
                 tokens_checked);
        if (mismatch_count == 0)
            $display("sexpr_byte_tokenizer verification clean");
        else
            $display("sexpr_byte_tokenizer verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/sbt_pkg.sv
sv/sbt_core.sv
sv/sbt_outq.sv
sv/sexpr_byte_tokenizer.sv
bench/sbt_token_checker.sv
bench/tb_sexpr_byte_tokenizer.sv
